[src/rpfl_pkg.sv]
package rpfl_pkg;

  // fixed field widths
  localparam int TIME_W = 32;
  localparam int FREQ_W = 32;
  localparam int PROD_W = 65;
  localparam int SUM_W  = 67;

  localparam logic signed [FREQ_W-1:0] FREQ_MAX = 32'sh7fff_ffff;
  localparam logic signed [FREQ_W-1:0] FREQ_MIN = 32'sh8000_0000;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_SKIP  = 3'd1;
  localparam logic [2:0] STAT_FULL  = 3'd2;
  localparam logic [2:0] STAT_RANGE = 3'd3;
  localparam logic [2:0] STAT_ORDER = 3'd4;

  typedef struct packed {
    logic [1:0]               action;
    logic [15:0]              point_order;
    logic signed [FREQ_W-1:0] point_rate;
    logic [TIME_W-1:0]        point_duration;
    logic                     instant;
    logic                     brake;
    logic                     point_power_on;
    logic [TIME_W-1:0]        query_time;
    logic signed [FREQ_W-1:0] initial_freq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [5:0]               segment_index;
    logic signed [FREQ_W-1:0] frequency;
    logic                     seg_power_on;
    logic                     seg_accel;
    logic [6:0]               segment_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]        start_time;
    logic [TIME_W-1:0]        end_time;
    logic signed [FREQ_W-1:0] start_freq;
    logic signed [FREQ_W-1:0] slope;
    logic                     power_on;
    logic                     accel;
  } seg_entry_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_ORDER_ERR,
    OP_INSTANT,
    OP_SKIP,
    OP_NO_ROOM,
    OP_UNUSED,
    OP_LOAD_MUL,
    OP_LOAD_COMMIT,
    OP_MISS,
    OP_SEARCH_INIT,
    OP_QUERY_READ,
    OP_STEP,
    OP_QUERY_MUL,
    OP_QUERY_DONE
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD_COMMIT,
    S_QUERY_READ,
    S_QUERY_CHECK,
    S_QUERY_MUL,
    S_QUERY_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic       instant;
    logic       order_bad;
    logic       dur_zero;
    logic       no_room;
    logic       count_zero;
    logic       hit;
    logic       step_empty;
  } dp_status_t;

  function automatic logic signed [FREQ_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-FREQ_W:0] top_bits;
    top_bits = v[SUM_W-1:FREQ_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      return v[FREQ_W-1:0];
    end
    return v[SUM_W-1] ? FREQ_MIN : FREQ_MAX;
  endfunction

endpackage

[src/rpfl_ctrl.sv]
module rpfl_ctrl
  import rpfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t dp_status,
  output dp_op_t     dp_op,
  output logic       busy,
  output logic       out_valid
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    dp_op         = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_op     = OP_CAPTURE;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (dp_status.action)
          ACT_CLEAR: dp_op = OP_CLEAR;
          ACT_LOAD: begin
            priority if (dp_status.order_bad) begin
              dp_op = OP_ORDER_ERR;
            end else if (dp_status.instant) begin
              dp_op = OP_INSTANT;
            end else if (dp_status.dur_zero) begin
              dp_op = OP_SKIP;
            end else if (dp_status.no_room) begin
              dp_op = OP_NO_ROOM;
            end else begin
              dp_op         = OP_LOAD_MUL;
              state_nxt     = S_LOAD_COMMIT;
              out_valid_nxt = 1'b0;
            end
          end
          ACT_QUERY: begin
            if (dp_status.count_zero) begin
              dp_op = OP_MISS;
            end else begin
              dp_op         = OP_SEARCH_INIT;
              state_nxt     = S_QUERY_READ;
              out_valid_nxt = 1'b0;
            end
          end
          ACT_UNUSED: dp_op = OP_UNUSED;
        endcase
      end
      S_LOAD_COMMIT: begin
        dp_op         = OP_LOAD_COMMIT;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      S_QUERY_READ: begin
        dp_op     = OP_QUERY_READ;
        state_nxt = S_QUERY_CHECK;
      end
      S_QUERY_CHECK: begin
        priority if (dp_status.hit) begin
          state_nxt = S_QUERY_MUL;
        end else if (dp_status.step_empty) begin
          dp_op         = OP_MISS;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          dp_op     = OP_STEP;
          state_nxt = S_QUERY_READ;
        end
      end
      S_QUERY_MUL: begin
        dp_op     = OP_QUERY_MUL;
        state_nxt = S_QUERY_DONE;
      end
      S_QUERY_DONE: begin
        dp_op         = OP_QUERY_DONE;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/rpfl_datapath.sv]
module rpfl_datapath
  import rpfl_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_op_t     dp_op,
  input  in_item_t   in_data,
  output dp_status_t dp_status,
  output out_item_t  out_data
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  seg_entry_t seg_mem [MAX_SEGMENTS];

  in_item_t                 in_r;
  seg_entry_t               rd_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic [TIME_W-1:0]        run_time_r, run_time_nxt;
  logic signed [FREQ_W-1:0] run_freq_r, run_freq_nxt;
  logic [15:0]              last_order_r, last_order_nxt;
  logic [AW-1:0]            lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_we;

  logic signed [FREQ_W-1:0] slope_in;
  logic [TIME_W:0]          time_sum;
  logic [CW-1:0]            count_inc, count_m1;
  logic [AW:0]              mid_sum;
  logic                     go_right;
  logic signed [FREQ_W-1:0] mul_a;
  logic [TIME_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [FREQ_W-1:0] load_freq, query_freq;
  seg_entry_t               wr_entry;

  // slope of the pending ramp, braking at the most negative rate saturates
  always_comb begin
    if (!in_r.brake) begin
      slope_in = in_r.point_rate;
    end else if (in_r.point_rate == FREQ_MIN) begin
      slope_in = FREQ_MAX;
    end else begin
      slope_in = -in_r.point_rate;
    end
  end

  assign time_sum  = {1'b0, run_time_r} + {1'b0, in_r.point_duration};
  assign count_inc = count_r + CW'(1);
  assign count_m1  = count_r - CW'(1);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign go_right  = (rd_r.start_time < in_r.query_time);

  // shared multiplier, operand choice by command
  always_comb begin
    if (dp_op == OP_QUERY_MUL) begin
      mul_a = rd_r.slope;
      mul_b = in_r.query_time - rd_r.start_time;
    end else begin
      mul_a = slope_in;
      mul_b = in_r.point_duration;
    end
  end

  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  // arithmetic shift floors toward minus infinity
  assign prod_sh    = prod_r >>> FRAC_BITS;
  assign load_freq  = sat32(SUM_W'(prod_sh) + SUM_W'(run_freq_r));
  assign query_freq = sat32(SUM_W'(prod_sh) + SUM_W'($signed(rd_r.start_freq))
                            + SUM_W'($signed(in_r.initial_freq)));

  always_comb begin
    wr_entry.start_time = run_time_r;
    wr_entry.end_time   = time_sum[TIME_W-1:0];
    wr_entry.start_freq = run_freq_r;
    wr_entry.slope      = slope_in;
    wr_entry.power_on   = in_r.point_power_on;
    wr_entry.accel      = !in_r.brake;
  end

  always_comb begin
    dp_status.action     = in_r.action;
    dp_status.instant    = in_r.instant;
    dp_status.order_bad  = (in_r.point_order < last_order_r);
    dp_status.dur_zero   = (in_r.point_duration == '0);
    dp_status.no_room    = (count_r >= CW'(MAX_SEGMENTS)) || time_sum[TIME_W];
    dp_status.count_zero = (count_r == '0);
    dp_status.hit        = (rd_r.start_time <= in_r.query_time) &&
                           (in_r.query_time < rd_r.end_time);
    dp_status.step_empty = go_right ? (mid_r == hi_r) : (mid_r == lo_r);
  end

  always_comb begin
    count_nxt      = count_r;
    run_time_nxt   = run_time_r;
    run_freq_nxt   = run_freq_r;
    last_order_nxt = last_order_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    out_we         = 1'b0;
    out_nxt               = '0;
    out_nxt.segment_count = 7'(count_r);
    out_nxt.frequency     = run_freq_r;
    unique case (dp_op)
      OP_CLEAR: begin
        count_nxt             = '0;
        run_time_nxt          = '0;
        run_freq_nxt          = '0;
        last_order_nxt        = '0;
        out_we                = 1'b1;
        out_nxt.segment_count = '0;
        out_nxt.frequency     = '0;
      end
      OP_ORDER_ERR: begin
        out_we         = 1'b1;
        out_nxt.status = STAT_ORDER;
      end
      OP_INSTANT: begin
        last_order_nxt    = in_r.point_order;
        run_freq_nxt      = in_r.point_rate;
        out_we            = 1'b1;
        out_nxt.status    = STAT_SKIP;
        out_nxt.frequency = in_r.point_rate;
      end
      OP_SKIP: begin
        last_order_nxt = in_r.point_order;
        out_we         = 1'b1;
        out_nxt.status = STAT_SKIP;
      end
      OP_NO_ROOM: begin
        out_we         = 1'b1;
        out_nxt.status = STAT_FULL;
      end
      OP_UNUSED: begin
        out_we            = 1'b1;
        out_nxt.frequency = '0;
      end
      OP_LOAD_COMMIT: begin
        last_order_nxt        = in_r.point_order;
        count_nxt             = count_inc;
        run_time_nxt          = time_sum[TIME_W-1:0];
        run_freq_nxt          = load_freq;
        out_we                = 1'b1;
        out_nxt.segment_count = 7'(count_inc);
        out_nxt.frequency     = load_freq;
      end
      OP_MISS: begin
        out_we            = 1'b1;
        out_nxt.status    = STAT_RANGE;
        out_nxt.frequency = in_r.initial_freq;
      end
      OP_SEARCH_INIT: begin
        lo_nxt = '0;
        hi_nxt = count_m1[AW-1:0];
      end
      OP_QUERY_READ: mid_nxt = mid_sum[AW:1];
      OP_STEP: begin
        if (go_right) begin
          lo_nxt = mid_r + AW'(1);
        end else begin
          hi_nxt = mid_r - AW'(1);
        end
      end
      OP_QUERY_DONE: begin
        out_we                = 1'b1;
        out_nxt.status        = STAT_OK;
        out_nxt.segment_index = 6'(mid_r);
        out_nxt.frequency     = query_freq;
        out_nxt.seg_power_on  = rd_r.power_on;
        out_nxt.seg_accel     = rd_r.accel;
      end
      OP_NONE, OP_CAPTURE, OP_LOAD_MUL, OP_QUERY_MUL: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      run_time_r   <= '0;
      run_freq_r   <= '0;
      last_order_r <= '0;
    end else begin
      count_r      <= count_nxt;
      run_time_r   <= run_time_nxt;
      run_freq_r   <= run_freq_nxt;
      last_order_r <= last_order_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (dp_op == OP_CAPTURE) begin
      in_r <= in_data;
    end
    if (dp_op == OP_LOAD_MUL || dp_op == OP_QUERY_MUL) begin
      prod_r <= prod_nxt;
    end
    if (out_we) begin
      out_r <= out_nxt;
    end
  end

  // segment table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (dp_op == OP_LOAD_COMMIT) begin
      seg_mem[count_r[AW-1:0]] <= wr_entry;
    end
    if (dp_op == OP_QUERY_READ) begin
      rd_r <= seg_mem[mid_sum[AW:1]];
    end
  end

  assign out_data = out_r;

endmodule

[src/ramp_profile_frequency_lookup.sv]
// accept to strobe: clear, rejected, skipped, instant points and empty-table queries
//   end at decode, an appended ramp after a commit state; a query of k probes reads
// and checks per probe, then a hit multiplies, a miss ends; k <= log2(depth)+1
// one item at a time, the next start is taken in the strobe cycle
// the receiver cannot stall; each result is shown for one cycle only
// synchronous active-low reset empties the table, no clearing pass is needed
module ramp_profile_frequency_lookup
  import rpfl_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  // command and status between the sequencer and the datapath
  dp_op_t     dp_op;
  dp_status_t dp_status;

  // sequencer: decodes the captured beat, walks the binary search
  rpfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .dp_op     (dp_op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: segment table, running state, shared multiplier, result register
  rpfl_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_op     (dp_op),
    .in_data   (in_data),
    .dp_status (dp_status),
    .out_data  (out_data)
  );

endmodule

[src/rpfl_checker.sv]
module rpfl_checker
  import rpfl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // a result beat only shows once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted beat keeps the block busy and gives no result in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted beat did not hold the block busy");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= STAT_ORDER))
    else $error("undefined status code");

  // a query miss reports no segment
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_RANGE) |->
      (out_data.segment_index == '0 && !out_data.seg_power_on && !out_data.seg_accel))
    else $error("query miss carries segment data");

endmodule

bind ramp_profile_frequency_lookup rpfl_checker u_rpfl_checker (.*);

[dv/ramp_profile_frequency_lookup_test.sv]
`timescale 1ns / 100ps

module ramp_profile_frequency_lookup_test;
  import rpfl_pkg::*;

  localparam int MAX_SEGS   = 64;
  localparam int FRAC       = 16;
  localparam int RAND_ITEMS = 550;
  // longer than the longest query, so this clears the pipe with margin
  localparam int DRAIN_CYCLES = 24;

  // one directed row: the beat, and a hand-typed answer where it is obvious
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  ramp_profile_frequency_lookup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // profile predictor: its own copy of the segment table and ramp state
  // ---------------------------------------------------------------------
  logic [31:0]        prof_start [MAX_SEGS];
  logic [31:0]        prof_end   [MAX_SEGS];
  logic signed [31:0] prof_base  [MAX_SEGS];
  logic signed [31:0] prof_slope [MAX_SEGS];
  logic               prof_pwr   [MAX_SEGS];
  logic               prof_accel [MAX_SEGS];
  int                 prof_count = 0;
  logic [31:0]        prof_time  = '0;
  logic signed [31:0] prof_freq  = '0;
  logic [15:0]        prof_order = '0;

  // clamp a wide sum to signed 32 bits
  function automatic logic signed [31:0] clamp_freq(longint v);
    if (v > longint'(FREQ_MAX)) return FREQ_MAX;
    if (v < longint'(FREQ_MIN)) return FREQ_MIN;
    return v[31:0];
  endfunction

  // binary search for the segment with start <= t < end, -1 on a miss
  function automatic int seg_search(logic [31:0] t);
    int lo, hi, mid;
    if (prof_count == 0) return -1;
    if (t < prof_start[0] || t >= prof_end[prof_count-1]) return -1;
    lo = 0;
    hi = prof_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (prof_start[mid] <= t && t < prof_end[mid]) return mid;
      if (prof_start[mid] < t) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // advance the profile by one beat and return the answer it should give
  function automatic out_item_t ramp_answer(in_item_t it);
    out_item_t          r;
    logic signed [31:0] rate, ofs, slope;
    longint             delta;
    int                 hit;
    r     = '0;
    rate  = it.point_rate;
    ofs   = it.initial_freq;
    case (it.action)
      ACT_CLEAR: begin
        prof_count = 0;
        prof_time  = '0;
        prof_freq  = '0;
        prof_order = '0;
      end
      ACT_LOAD: begin
        if (it.point_order < prof_order) begin
          r.status = STAT_ORDER;
        end else if (it.instant) begin
          // jump to the target frequency, no time passes
          prof_order = it.point_order;
          prof_freq  = rate;
          r.status   = STAT_SKIP;
        end else if (it.point_duration == '0) begin
          prof_order = it.point_order;
          r.status   = STAT_SKIP;
        end else if (prof_count >= MAX_SEGS ||
                     {1'b0, prof_time} + {1'b0, it.point_duration} > 33'h0_ffff_ffff) begin
          r.status = STAT_FULL;
        end else begin
          // braking negates the rate, the most negative rate clamps
          slope = it.brake ? clamp_freq(-longint'(rate)) : rate;
          delta = (longint'(slope) * longint'(it.point_duration)) >>> FRAC;
          prof_order             = it.point_order;
          prof_start[prof_count] = prof_time;
          prof_end[prof_count]   = prof_time + it.point_duration;
          prof_base[prof_count]  = prof_freq;
          prof_slope[prof_count] = slope;
          prof_pwr[prof_count]   = it.point_power_on;
          prof_accel[prof_count] = !it.brake;
          prof_count++;
          prof_time = prof_time + it.point_duration;
          prof_freq = clamp_freq(longint'(prof_freq) + delta);
        end
        r.frequency = prof_freq;
      end
      ACT_QUERY: begin
        hit = seg_search(it.query_time);
        if (hit < 0) begin
          r.status    = STAT_RANGE;
          r.frequency = ofs;
        end else begin
          // floor of slope * elapsed, then base and offset, clamped
          delta = (longint'(prof_slope[hit]) *
                   longint'(it.query_time - prof_start[hit])) >>> FRAC;
          r.frequency     = clamp_freq(delta + longint'(prof_base[hit]) + longint'(ofs));
          r.segment_index = hit[5:0];
          r.seg_power_on  = prof_pwr[hit];
          r.seg_accel     = prof_accel[hit];
        end
      end
      default: ;
    endcase
    r.segment_count = 7'(prof_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------
  stim_row_t stim_marks [$];
  out_item_t answer_q [$];
  int        mismatches = 0;

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (answer_q.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, got);
      mismatches++;
      return;
    end
    want = answer_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.segment_index !== want.segment_index) begin
      $display("%0t: segment_index expected %0d got %0d", $time,
               want.segment_index, got.segment_index);
      mismatches++;
    end
    if (got.frequency !== want.frequency) begin
      $display("%0t: frequency expected %h got %h", $time, want.frequency, got.frequency);
      mismatches++;
    end
    if (got.seg_power_on !== want.seg_power_on) begin
      $display("%0t: seg_power_on expected %b got %b", $time,
               want.seg_power_on, got.seg_power_on);
      mismatches++;
    end
    if (got.seg_accel !== want.seg_accel) begin
      $display("%0t: seg_accel expected %b got %b", $time, want.seg_accel, got.seg_accel);
      mismatches++;
    end
    if (got.segment_count !== want.segment_count) begin
      $display("%0t: segment_count expected %0d got %0d", $time,
               want.segment_count, got.segment_count);
      mismatches++;
    end
  endtask

  // results are checked before the beat taken at the same edge is predicted
  always @(posedge clk) begin
    stim_row_t row;
    out_item_t pred;
    if (rst_n) begin
      if (out_valid) check_beat(out_data);
      if (start && !busy) begin
        row  = stim_marks.pop_front();
        pred = ramp_answer(in_data);
        answer_q.insert(answer_q.size(), row.typed ? row.res : pred);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  int          idle_pct = 0;
  int          sent = 0;
  logic [15:0] gen_order = '0;
  logic [31:0] gen_time = '0;   // rough guide to the profile length

  function automatic in_item_t mk_item(logic [1:0] act, logic [15:0] ord,
                                       logic [31:0] rate, logic [31:0] dur,
                                       logic inst, logic brk, logic pwr,
                                       logic [31:0] qt, logic [31:0] ofs);
    in_item_t it;
    it.action         = act;
    it.point_order    = ord;
    it.point_rate     = rate;
    it.point_duration = dur;
    it.instant        = inst;
    it.brake          = brk;
    it.point_power_on = pwr;
    it.query_time     = qt;
    it.initial_freq   = ofs;
    return it;
  endfunction

  function automatic out_item_t fixed_res(logic [2:0] st, logic [31:0] f, int cnt);
    out_item_t r;
    r               = '0;
    r.status        = st;
    r.frequency     = f;
    r.segment_count = 7'(cnt);
    return r;
  endfunction

  // hold start until the beat is taken, with random idle cycles before it
  task automatic send_beat(in_item_t it, bit typed, out_item_t res);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    stim_marks.insert(stim_marks.size(), row);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return FREQ_MAX;
      1: return FREQ_MIN;
      2: return '0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_dur(bit short_only);
    if (short_only) return $urandom_range(1, 32'h0004_0000);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(1, 255);
      2: return $urandom;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // a load point, mostly in order; keeps the rough profile length up to date
  function automatic in_item_t make_load(bit short_only);
    in_item_t it;
    int       ord;
    logic     inst;
    logic [31:0] dur;
    if ($urandom_range(0, 9) == 0) ord = $urandom_range(0, 16'hffff);
    else ord = gen_order + $urandom_range(0, 2);
    if (ord > 16'hffff) ord = 16'hffff;
    inst = ($urandom_range(0, 9) == 0);
    dur  = pick_dur(short_only);
    it   = mk_item(ACT_LOAD, ord[15:0], pick_rate(), dur, inst, $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom, pick_rate());
    if (ord[15:0] >= gen_order) begin
      gen_order = ord[15:0];
      if (!inst && {1'b0, gen_time} + {1'b0, dur} <= 33'h0_ffff_ffff)
        gen_time = gen_time + dur;
    end
    return it;
  endfunction

  // query times mostly inside the profile, some at its end, some anywhere
  function automatic in_item_t make_query();
    logic [31:0] qt;
    case ($urandom_range(0, 4))
      0: qt = $urandom;
      1: qt = gen_time + $urandom_range(0, 4) - 2;
      default: qt = $urandom_range(0, gen_time);
    endcase
    return mk_item(ACT_QUERY, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1), qt, pick_rate());
  endfunction

  // a clear, a run of loads with queries between, then a burst of queries;
  // now and then a long run that overfills the table, or a single noise beat
  task automatic run_profile();
    int n_loads;
    bit fill;
    if ($urandom_range(0, 99) < 15) begin
      send_beat(mk_item($urandom_range(0, 3), $urandom, $urandom, $urandom,
                        $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom, $urandom), 1'b0, '0);
      return;
    end
    fill    = ($urandom_range(0, 11) == 0);
    n_loads = fill ? $urandom_range(72, 80) : $urandom_range(1, 12);
    send_beat(mk_item(ACT_CLEAR, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0,
                      $urandom, $urandom), 1'b0, '0);
    gen_order = '0;
    gen_time  = '0;
    repeat (n_loads) begin
      send_beat(make_load(fill), 1'b0, '0);
      if ($urandom_range(0, 3) == 0) send_beat(make_query(), 1'b0, '0);
    end
    repeat ($urandom_range(2, 8)) send_beat(make_query(), 1'b0, '0);
  endtask

  stim_row_t dir_rows [$];

  // append one directed row to the table
  function automatic void add_row(in_item_t it, bit typed, out_item_t res);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    int idle_phases [4];
    int base;
    idle_phases = '{0, 52, 0, 21};

    // directed rows: edges of the fields and each special case in turn
    // query on an empty table misses and returns the offset
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678), 1,
            fixed_res(STAT_RANGE, 32'h1234_5678, 0));
    // unused action with every field high changes nothing
    add_row(mk_item(ACT_UNUSED, 16'hffff, '1, '1, 1, 1, 1, '1, '1), 1,
            fixed_res(STAT_OK, 0, 0));
    // instant point to the top frequency
    add_row(mk_item(ACT_LOAD, 5, FREQ_MAX, 0, 1, 0, 0, 0, 0), 1,
            fixed_res(STAT_SKIP, FREQ_MAX, 0));
    // order going backwards is refused
    add_row(mk_item(ACT_LOAD, 3, 32'h100, 32'h1_0000, 0, 0, 0, 0, 0), 1,
            fixed_res(STAT_ORDER, FREQ_MAX, 0));
    // zero duration ramp is skipped
    add_row(mk_item(ACT_LOAD, 5, 32'h100, 0, 0, 0, 0, 0, 0), 1,
            fixed_res(STAT_SKIP, FREQ_MAX, 0));
    // braking at the most negative rate, running frequency clamps high
    add_row(mk_item(ACT_LOAD, 6, FREQ_MIN, 32'h1_0000, 0, 1, 1, 0, 0), 0, '0);
    add_row(mk_item(ACT_LOAD, 7, 0, 0, 1, 0, 0, 0, 0), 1,
            fixed_res(STAT_SKIP, 0, 1));
    add_row(mk_item(ACT_LOAD, 8, 32'h1_0000, 32'h2_0000, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(ACT_LOAD, 16'hffff, FREQ_MIN, 32'h8000, 0, 0, 1, 0, 0), 0, '0);
    // hits at the first instant, clamped high, at a boundary, at the last tick
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff, FREQ_MAX), 0, '0);
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h1_0000, FREQ_MIN), 0, '0);
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h3_7fff, 0), 0, '0);
    // end of the profile and the top of the time range both miss
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h3_8000, 32'h55), 1,
            fixed_res(STAT_RANGE, 32'h55, 3));
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, '1, '1), 1,
            fixed_res(STAT_RANGE, '1, 3));
    // time would run past 32 bits
    add_row(mk_item(ACT_LOAD, 16'hffff, 1, '1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            fixed_res(STAT_OK, 0, 0));
    // one ramp over the whole time range, braking hard; clamps low
    add_row(mk_item(ACT_LOAD, 0, FREQ_MAX, '1, 0, 1, 0, 0, 0), 0, '0);
    add_row(mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_fffe, 0), 0, '0);
    add_row(mk_item(ACT_LOAD, 1, 1, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            fixed_res(STAT_OK, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // random profiles in four idling phases
    base = sent;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_phases[ph];
      while (sent < base + (ph + 1) * RAND_ITEMS / 4) run_profile();
    end
    start <= 1'b0;

    while (answer_q.size() != 0 || stim_marks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
